### design/hzb_pkg.sv
`default_nettype none
package hzb_pkg;

  // Screen and pyramid geometry
  localparam int WIDTH        = 64;
  localparam int HEIGHT       = 64;
  localparam int FINEST_LEVEL = 5;
  localparam int LVL_W        = 3;
  localparam int COORD_W      = 6;
  localparam int DEPTH_W      = 24;
  localparam int BOX_W        = 10;
  localparam int ADDR_W       = 13;
  localparam int CELLS        = 5460;

  localparam logic [DEPTH_W-1:0] FAR_DEPTH = '1;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_BOX   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  // One classified item as it travels from front to back
  typedef struct packed {
    cmd_e               cmd;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DEPTH_W-1:0] depth;
    logic [LVL_W-1:0]   lvl;
    logic [COORD_W-1:0] c0;
    logic [COORD_W-1:0] c1;
    logic [COORD_W-1:0] r0;
    logic [COORD_W-1:0] r1;
    logic               early;
  } hzb_item_t;

  // Linear store address of cell (x, y) at level l; level l is (2 << l) cells wide
  function automatic logic [ADDR_W-1:0] cell_addr(logic [LVL_W-1:0] l,
                                                  logic [COORD_W-1:0] x,
                                                  logic [COORD_W-1:0] y);
    logic [ADDR_W-1:0] base;
    case (l)
      3'd0:    base = 13'd0;
      3'd1:    base = 13'd4;
      3'd2:    base = 13'd20;
      3'd3:    base = 13'd84;
      3'd4:    base = 13'd340;
      3'd5:    base = 13'd1364;
      default: base = 13'd0;
    endcase
    return base + (ADDR_W'(y) << (l + 3'd1)) + ADDR_W'(x);
  endfunction

endpackage
`default_nettype wire

### design/hzb_ram.sv
`default_nettype none
module hzb_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 5460,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

### design/hzb_fifo.sv
`default_nettype none
module hzb_fifo import hzb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire hzb_item_t item_i,
  output logic           ready_o,
  output logic           valid_o,
  input  wire logic      pop_i,
  output hzb_item_t      item_o
);

  hzb_item_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rp_q];

  // Two-entry queue between classify and execute
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= item_i;
  end

endmodule
`default_nettype wire

### design/hzb_front.sv
`default_nettype none
module hzb_front import hzb_pkg::*; (
  input  wire logic [1:0]         command_i,
  input  wire logic [COORD_W-1:0] pixel_x_i,
  input  wire logic [COORD_W-1:0] pixel_y_i,
  input  wire logic [DEPTH_W-1:0] pixel_depth_i,
  input  wire logic               box_empty_i,
  input  wire logic [BOX_W-1:0]   box_min_x_i,
  input  wire logic [BOX_W-1:0]   box_min_y_i,
  input  wire logic [BOX_W-1:0]   box_max_x_i,
  input  wire logic [BOX_W-1:0]   box_max_y_i,
  input  wire logic [DEPTH_W-1:0] box_near_depth_i,
  output hzb_item_t               item_o
);

  logic signed [BOX_W:0] dx, dy, len;
  logic [LVL_W-1:0]      s;
  logic [COORD_W-1:0]    c0, c1, r0, r1;

  // Pick the coarsening step from the larger box extent
  always_comb begin
    dx  = $signed({1'b0, box_max_x_i}) - $signed({1'b0, box_min_x_i});
    dy  = $signed({1'b0, box_max_y_i}) - $signed({1'b0, box_min_y_i});
    len = (dy > dx) ? dy : dx;
    s   = LVL_W'(FINEST_LEVEL);
    for (int i = FINEST_LEVEL - 1; i >= 0; i--) begin
      if (len <= $signed((BOX_W+1)'(16 << i))) s = LVL_W'(i);
    end
  end

  // Edge to cell index; 10-bit edges never pass the last cell of the level
  assign c0 = COORD_W'(box_min_x_i >> ({1'b0, s} + 4'd4));
  assign c1 = COORD_W'(box_max_x_i >> ({1'b0, s} + 4'd4));
  assign r0 = COORD_W'(box_min_y_i >> ({1'b0, s} + 4'd4));
  assign r1 = COORD_W'(box_max_y_i >> ({1'b0, s} + 4'd4));

  always_comb begin
    item_o.cmd   = cmd_e'(command_i);
    item_o.x     = pixel_x_i;
    item_o.y     = pixel_y_i;
    item_o.depth = (cmd_e'(command_i) == CMD_BOX) ? box_near_depth_i : pixel_depth_i;
    item_o.lvl   = LVL_W'(FINEST_LEVEL) - s;
    item_o.c0    = c0;
    item_o.c1    = c1;
    item_o.r0    = r0;
    item_o.r1    = r1;
    // Empty or inverted box is rejected without a read
    item_o.early = box_empty_i | (c0 > c1) | (r0 > r1);
  end

endmodule
`default_nettype wire

### design/hzb_back.sv
`default_nettype none
module hzb_back import hzb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire hzb_item_t item_i,
  output logic           pop_o,
  output logic           init_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic           verdict_o
);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PIX, ST_UP, ST_BOX, ST_DONE
  } state_e;

  state_e             state_q, state_d;
  logic [ADDR_W-1:0]  cnt_q, cnt_d;
  logic               rd_v_q, rd_v_d;
  logic [2:0]         rd_k_q, rd_k_d;
  hzb_item_t          it_q, it_d;
  logic [DEPTH_W-1:0] max_q, max_d;
  logic               hit_q, hit_d;
  logic               res_q, res_d;
  logic               init_q, init_d;
  logic               out_valid_q, out_valid_d;
  logic               out_q, out_d;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [DEPTH_W-1:0] ram_wdata, ram_rdata;
  logic [2:0]         k;
  logic [COORD_W-1:0] px, py;

  hzb_ram #(.DATA_W(DEPTH_W), .DEPTH(CELLS), .ADDR_W(ADDR_W)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign init_o      = init_q;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = out_q;
  assign k           = cnt_q[2:0];
  assign px          = it_q.x >> 1;
  assign py          = it_q.y >> 1;

  // Sequencer: one store access per cycle, reads overlap with data return
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_v_d      = 1'b0;
    rd_k_d      = k;
    it_d        = it_q;
    max_d       = max_q;
    hit_d       = hit_q;
    res_d       = res_q;
    init_d      = init_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_addr    = '0;
    ram_wdata   = FAR_DEPTH;
    case (state_q)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = cnt_q;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          init_d  = 1'b0;
          res_d   = 1'b0;
          state_d = init_q ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          it_d  = item_i;
          cnt_d = '0;
          hit_d = 1'b0;
          case (item_i.cmd)
            CMD_PIXEL: state_d = ST_PIX;
            CMD_BOX: begin
              res_d   = 1'b1;
              state_d = item_i.early ? ST_DONE : ST_BOX;
            end
            CMD_CLEAR: state_d = ST_CLEAR;
            default: begin
              res_d   = 1'b0;
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_PIX: begin
        ram_addr = cell_addr(LVL_W'(FINEST_LEVEL), it_q.x, it_q.y);
        if (cnt_q == '0) begin
          rd_v_d = 1'b1;
          cnt_d  = 13'd1;
        end else if (rd_v_q) begin
          if (it_q.depth < ram_rdata) begin
            ram_we    = 1'b1;
            ram_wdata = it_q.depth;
            it_d.lvl  = LVL_W'(FINEST_LEVEL - 1);
            cnt_d     = '0;
            state_d   = ST_UP;
          end else begin
            res_d   = 1'b0;
            state_d = ST_DONE;
          end
        end
      end
      ST_UP: begin
        // Reads 0..3 fetch the children, read 4 the parent
        if (cnt_q <= 13'd4) begin
          rd_v_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          if (k == 3'd4) begin
            ram_addr = cell_addr(it_q.lvl, px, py);
          end else begin
            ram_addr = cell_addr(it_q.lvl + 3'd1, {px[COORD_W-2:0], k[0]},
                                 {py[COORD_W-2:0], k[1]});
          end
        end
        if (rd_v_q) begin
          if (rd_k_q == 3'd0) begin
            max_d = ram_rdata;
          end else if (rd_k_q != 3'd4) begin
            max_d = (ram_rdata > max_q) ? ram_rdata : max_q;
          end else if (ram_rdata == max_q) begin
            res_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            ram_we    = 1'b1;
            ram_addr  = cell_addr(it_q.lvl, px, py);
            ram_wdata = max_q;
            if (it_q.lvl == '0) begin
              res_d   = 1'b1;
              state_d = ST_DONE;
            end else begin
              it_d.lvl = it_q.lvl - 3'd1;
              it_d.x   = px;
              it_d.y   = py;
              cnt_d    = '0;
            end
          end
        end
      end
      ST_BOX: begin
        // Up to 2x2 covering cells; repeated corners are harmless
        if (cnt_q <= 13'd3) begin
          rd_v_d   = 1'b1;
          cnt_d    = cnt_q + 1'b1;
          ram_addr = cell_addr(it_q.lvl, k[0] ? it_q.c1 : it_q.c0,
                               k[1] ? it_q.r1 : it_q.r0);
        end
        if (rd_v_q) begin
          hit_d = hit_q | (ram_rdata > it_q.depth);
          if (rd_k_q == 3'd3) begin
            res_d   = ~hit_d;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      rd_v_q      <= 1'b0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_v_q      <= rd_v_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_k_q <= rd_k_d;
    it_q   <= it_d;
    max_q  <= max_d;
    hit_q  <= hit_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

endmodule
`default_nettype wire

### design/hierarchical_z_buffer.sv
`default_nettype none
// Max-depth Z pyramid over a 64x64 screen (levels 2x2 up to 64x64, 5460 cells in one
// single-port memory). Commands: pixel test and write, box rejection query, clear, no-op.
// After reset the block sweeps the memory to far depth with in_ready_o low; a clear
// command runs the same sweep. A failing pixel test reads the finest cell and stops.
// On a pass it writes the cell and then, per pyramid level walked, does four child
// reads, a parent read, then the write or the stop, stopping at the first unchanged
// parent or after level 0 is written. A box query reads up to four covering cells; an
// empty or inverted box is answered without a read. A two-entry queue takes new items
// while the back end works, and the result register holds one verdict for the consumer;
// the back end waits in its done state while that verdict is still untaken.
module hierarchical_z_buffer import hzb_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         command_i,
  input  wire logic [COORD_W-1:0] pixel_x_i,
  input  wire logic [COORD_W-1:0] pixel_y_i,
  input  wire logic [DEPTH_W-1:0] pixel_depth_i,
  input  wire logic               box_empty_i,
  input  wire logic [BOX_W-1:0]   box_min_x_i,
  input  wire logic [BOX_W-1:0]   box_min_y_i,
  input  wire logic [BOX_W-1:0]   box_max_x_i,
  input  wire logic [BOX_W-1:0]   box_max_y_i,
  input  wire logic [DEPTH_W-1:0] box_near_depth_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    verdict_o
);

  hzb_item_t front_item, queue_item;
  logic      q_ready, q_valid, q_pop, init, push;

  assign in_ready_o = q_ready & ~init;
  assign push       = in_valid_i & in_ready_o;

  hzb_front u_front (
    .command_i       (command_i),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .pixel_depth_i   (pixel_depth_i),
    .box_empty_i     (box_empty_i),
    .box_min_x_i     (box_min_x_i),
    .box_min_y_i     (box_min_y_i),
    .box_max_x_i     (box_max_x_i),
    .box_max_y_i     (box_max_y_i),
    .box_near_depth_i(box_near_depth_i),
    .item_o          (front_item)
  );

  hzb_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (front_item),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .item_o (queue_item)
  );

  hzb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (q_valid),
    .item_i     (queue_item),
    .pop_o      (q_pop),
    .init_o     (init),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .verdict_o  (verdict_o)
  );

endmodule
`default_nettype wire
